@@ src/htpg_pkg.sv @@
// Shared types, widths and codes of the hash table put/get/remove unit.
package htpg_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int REQ_W = 2;
  localparam int ST_W = 2;

  localparam int BUCKETS_DEF = 16;
  localparam int WAYS_DEF = 4;

  // The bucket index is formed four key bits per step, most significant digit first.
  localparam int DIGIT_W = 4;
  localparam int DIGITS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
  localparam int PAD_W = DIGITS * DIGIT_W;
  localparam int DIG_CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam logic [REQ_W-1:0] REQ_PUT = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_GET = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_REMOVE = REQ_W'(2);

  localparam logic [ST_W-1:0] ST_DONE = ST_W'(0);
  localparam logic [ST_W-1:0] ST_ABSENT = ST_W'(1);
  localparam logic [ST_W-1:0] ST_FULL = ST_W'(2);

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic mod_step;
    logic set_base;
    logic scan;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mod_last;
    logic scan_done;
  } sts_t;

endpackage

@@ src/htpg_mem.sv @@
// Slot memory with one write port and one registered read port.
module htpg_mem
  import htpg_pkg::*;
#(
  parameter int DEPTH = BUCKETS_DEF * WAYS_DEF,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/htpg_ctrl.sv @@
// Controller state machine that sequences clearing, bucket index, scan and update.
module htpg_ctrl
  import htpg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_BASE,
    S_SCAN,
    S_DECIDE
  } state_e;

  state_e state_q;
  logic   busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (sts_i.clear_last) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_MOD;
            busy_q  <= 1'b1;
          end
        end
        S_MOD: begin
          if (sts_i.mod_last) begin
            state_q <= S_BASE;
          end
        end
        S_BASE: begin
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.clear    = (state_q == S_CLEAR);
    cmd_o.load     = (state_q == S_IDLE) && start_i;
    cmd_o.mod_step = (state_q == S_MOD);
    cmd_o.set_base = (state_q == S_BASE);
    cmd_o.scan     = (state_q == S_SCAN);
    cmd_o.decide   = (state_q == S_DECIDE);
  end

  assign busy_o = busy_q;

endmodule

@@ src/htpg_datapath.sv @@
// Datapath: request registers, bucket remainder, slot scan and update decision.
module htpg_datapath
  import htpg_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS = WAYS_DEF,
  parameter int AW = (BUCKETS * WAYS > 1) ? $clog2(BUCKETS * WAYS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    mem_we_o,
  output logic [AW-1:0]           mem_waddr_o,
  output entry_t                  mem_wdata_o,
  output logic                    mem_re_o,
  output logic [AW-1:0]           mem_raddr_o,
  input  entry_t                  mem_rdata_i,
  output logic                    done_o,
  output logic [ST_W-1:0]         status_o,
  output logic signed [VAL_W-1:0] read_value_o
);

  localparam int SLOTS = BUCKETS * WAYS;
  localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW = IW + DIGIT_W;
  localparam int WCW = $clog2(WAYS + 1);
  localparam int STEPS = (1 << DIGIT_W) - 1;

  logic [REQ_W-1:0] req_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [PAD_W-1:0] ksh_q;
  logic [IW-1:0]    rem_q;
  logic [DIG_CW-1:0] dig_q;
  logic [AW-1:0]    base_q;
  logic [WCW-1:0]   way_q;
  logic             rvld_q;
  logic [WCW-1:0]   rway_q;
  logic             hit_q;
  logic [WCW-1:0]   hit_way_q;
  logic [VAL_W-1:0] hit_val_q;
  logic             free_q;
  logic [WCW-1:0]   free_way_q;
  logic [AW-1:0]    clr_q;
  logic             done_q;
  logic [ST_W-1:0]  status_q;
  logic [VAL_W-1:0] rdval_q;

  logic [RW-1:0]    r_ext;
  logic [RW-1:0]    r_new;
  logic             issue;
  logic             dec_we;
  logic [WCW-1:0]   dec_way;
  entry_t           dec_wdata;
  logic [ST_W-1:0]  status_d;
  logic [VAL_W-1:0] rdval_d;

  // One remainder step: shift in a digit and take off the largest multiple of BUCKETS.
  always_comb begin
    r_ext = {rem_q, ksh_q[PAD_W-1 -: DIGIT_W]};
    r_new = r_ext;
    for (int k = 1; k <= STEPS; k++) begin
      if (r_ext >= RW'(k * BUCKETS)) begin
        r_new = r_ext - RW'(k * BUCKETS);
      end
    end
  end

  assign issue = cmd_i.scan && (way_q < WCW'(WAYS));

  always_comb begin
    dec_we          = 1'b0;
    dec_way         = hit_q ? hit_way_q : free_way_q;
    dec_wdata.valid = 1'b1;
    dec_wdata.key   = key_q;
    dec_wdata.value = val_q;
    status_d        = ST_ABSENT;
    rdval_d         = '1;
    unique case (req_q)
      REQ_PUT: begin
        if (hit_q || free_q) begin
          dec_we   = 1'b1;
          status_d = ST_DONE;
        end else begin
          status_d = ST_FULL;
        end
      end
      REQ_GET: begin
        if (hit_q) begin
          rdval_d  = hit_val_q;
          status_d = ST_DONE;
        end
      end
      REQ_REMOVE: begin
        if (hit_q) begin
          dec_we          = 1'b1;
          dec_wdata.valid = 1'b0;
          status_d        = ST_DONE;
        end
      end
      default: begin
        status_d = ST_ABSENT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q  <= '0;
      way_q  <= '0;
      rvld_q <= 1'b0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.decide;
      rvld_q <= issue;
      if (cmd_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.load) begin
        dig_q  <= '0;
        way_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
      if (cmd_i.mod_step) begin
        dig_q <= dig_q + DIG_CW'(1);
      end
      if (issue) begin
        way_q <= way_q + WCW'(1);
      end
      if (rvld_q) begin
        if (mem_rdata_i.valid && (mem_rdata_i.key == key_q) && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!mem_rdata_i.valid && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      key_q <= key_i;
      val_q <= value_i;
      ksh_q <= PAD_W'(key_i);
      rem_q <= '0;
    end
    if (cmd_i.mod_step) begin
      ksh_q <= ksh_q << DIGIT_W;
      rem_q <= IW'(r_new);
    end
    if (cmd_i.set_base) begin
      base_q <= AW'(32'(rem_q) * WAYS);
    end
    if (issue) begin
      rway_q <= way_q;
    end
    if (rvld_q) begin
      if (mem_rdata_i.valid && (mem_rdata_i.key == key_q) && !hit_q) begin
        hit_way_q <= rway_q;
        hit_val_q <= mem_rdata_i.value;
      end
      if (!mem_rdata_i.valid && !free_q) begin
        free_way_q <= rway_q;
      end
    end
    if (cmd_i.decide) begin
      status_q <= status_d;
      rdval_q  <= rdval_d;
    end
  end

  assign sts_o.clear_last = (clr_q == AW'(SLOTS - 1));
  assign sts_o.mod_last   = (dig_q == DIG_CW'(DIGITS - 1));
  assign sts_o.scan_done  = rvld_q && (rway_q == WCW'(WAYS - 1));

  assign mem_re_o    = issue;
  assign mem_raddr_o = base_q + AW'(way_q);
  assign mem_we_o    = cmd_i.clear || (cmd_i.decide && dec_we);
  assign mem_waddr_o = cmd_i.clear ? clr_q : (base_q + AW'(dec_way));
  assign mem_wdata_o = cmd_i.clear ? entry_t'('0) : dec_wdata;

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = rdval_q;

endmodule

@@ src/hash_table_put_get_remove_unit.sv @@
// Top level of the hash table put/get/remove unit with bounded slots per bucket.
// A result word is strobed after the request's remainder, base, scan and decide steps.
// The key remainder is formed digit-serially, and the bucket's WAYS slots are read one by
// one through the single memory read port; a new request is taken only once busy falls.
// After reset every slot of the memory is swept clear with busy high.
// Results are strobed for one cycle on done_o; the receiver cannot stall.
module hash_table_put_get_remove_unit
  import htpg_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS = WAYS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    done_o,
  output logic [ST_W-1:0]         status_o,
  output logic signed [VAL_W-1:0] read_value_o
);

  localparam int SLOTS = BUCKETS * WAYS;
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  htpg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  htpg_datapath #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS),
    .AW     (AW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .done_o      (done_o),
    .status_o    (status_o),
    .read_value_o(read_value_o)
  );

  htpg_mem #(
    .DEPTH(SLOTS),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted word did not raise busy.");

  a_done_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("Result word strobed without a request in progress.");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result word strobed twice.");

  a_miss_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_DONE)) |-> (read_value_o == '1))
    else $error("Unsuccessful request returned a value other than all ones.");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench of the hash table put/get/remove unit with a predicting scoreboard.
module tb_top;
  import htpg_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = REQ_W'(3);
  localparam int SLOTS = BUCKETS_DEF * WAYS_DEF;
  localparam int RANDOM_ITEMS = 930;
  localparam int KEY_POOL = 32;

  typedef struct {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] read_value;
  } outcome_t;

  class kv_table_predictor;
    logic [KEY_W-1:0]        slot_key[SLOTS];
    logic signed [VAL_W-1:0] slot_val[SLOTS];
    bit                      slot_vld[SLOTS];
    outcome_t                pending[$];
    int errors;
    int n_req, n_store, n_update, n_hit, n_full, n_freed, n_absent;

    function new();
      foreach (slot_vld[i]) slot_vld[i] = 1'b0;
      errors = 0;
      n_req = 0;
      n_store = 0;
      n_update = 0;
      n_hit = 0;
      n_full = 0;
      n_freed = 0;
      n_absent = 0;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                               logic signed [VAL_W-1:0] value);
      int base;
      int hit;
      int free_s;
      outcome_t o;
      base = int'(key % KEY_W'(BUCKETS_DEF)) * WAYS_DEF;
      hit = -1;
      free_s = -1;
      for (int w = 0; w < WAYS_DEF; w++) begin
        if (slot_vld[base + w] && slot_key[base + w] == key && hit < 0) hit = base + w;
        if (!slot_vld[base + w] && free_s < 0) free_s = base + w;
      end
      o.status = ST_ABSENT;
      o.read_value = '1;
      case (req)
        REQ_PUT: begin
          if (hit >= 0) begin
            slot_val[hit] = value;
            o.status = ST_DONE;
            n_update++;
          end else if (free_s >= 0) begin
            slot_key[free_s] = key;
            slot_val[free_s] = value;
            slot_vld[free_s] = 1'b1;
            o.status = ST_DONE;
            n_store++;
          end else begin
            o.status = ST_FULL;
            n_full++;
          end
        end
        REQ_GET: begin
          if (hit >= 0) begin
            o.read_value = slot_val[hit];
            o.status = ST_DONE;
            n_hit++;
          end
        end
        REQ_REMOVE: begin
          if (hit >= 0) begin
            slot_vld[hit] = 1'b0;
            o.status = ST_DONE;
            n_freed++;
          end
        end
        default: ;
      endcase
      if (o.status == ST_ABSENT) n_absent++;
      n_req++;
      pending.insert(pending.size(), o);
    endfunction

    function void check_response(logic [ST_W-1:0] status, logic signed [VAL_W-1:0] read_value);
      outcome_t o;
      if (pending.size() == 0) begin
        $error("Result word with no request outstanding: status %0d read_value %0d",
               status, read_value);
        errors++;
        return;
      end
      o = pending.pop_front();
      if (status !== o.status) begin
        $error("status: expected %0d, actual %0d", o.status, status);
        errors++;
      end
      if (read_value !== o.read_value) begin
        $error("read_value: expected %0d, actual %0d", o.read_value, read_value);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [REQ_W-1:0]        req_type_i;
  logic [KEY_W-1:0]        key_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    done_o;
  logic [ST_W-1:0]         status_o;
  logic signed [VAL_W-1:0] read_value_o;

  kv_table_predictor pred = new();
  logic [KEY_W-1:0] key_pool[KEY_POOL];

  hash_table_put_get_remove_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .read_value_o(read_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("hash_table_put_get_remove_unit test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) pred.check_response(status_o, read_value_o);
  end

  task automatic send_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                              logic signed [VAL_W-1:0] value);
    @(negedge clk_i);
    start <= 1'b1;
    req_type_i <= req;
    key_i <= key;
    value_i <= value;
    do @(posedge clk_i); while (busy !== 1'b0);
    pred.note_request(req, key, value);
  endtask

  // Idle cycles carry random field values so that only start qualifies a word.
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
      req_type_i <= REQ_W'($urandom);
      key_i <= KEY_W'($urandom);
      value_i <= VAL_W'($urandom);
    end
  endtask

  task automatic wait_all_results();
    idle_cycles(1);
    while (pred.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic refill_key_pool();
    int offset;
    offset = $urandom_range(0, 8);
    foreach (key_pool[i]) key_pool[i] = {27'($urandom), 4'($urandom_range(0, 7) + offset)};
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return KEY_W'($urandom);
    return key_pool[$urandom_range(0, KEY_POOL - 1)];
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return REQ_PUT;
    if (r < 75) return REQ_GET;
    if (r < 95) return REQ_REMOVE;
    return REQ_UNUSED;
  endfunction

  initial begin
    int burst;
    int sent;
    rst_ni = 1'b0;
    start = 1'b0;
    req_type_i = REQ_PUT;
    key_i = '0;
    value_i = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_request(REQ_GET, 31'd0, 32'sd5);
    send_request(REQ_PUT, 31'd0, 32'sh7fffffff);
    send_request(REQ_GET, 31'd0, 32'sd0);
    send_request(REQ_PUT, 31'h7fffffff, 32'sh80000000);
    send_request(REQ_GET, 31'h7fffffff, 32'sd0);
    send_request(REQ_PUT, 31'd0, -32'sd1);
    send_request(REQ_GET, 31'd0, 32'sd0);
    send_request(REQ_PUT, 31'd3, 32'sd11);
    send_request(REQ_PUT, 31'd19, 32'sd22);
    send_request(REQ_PUT, 31'd35, 32'sd33);
    send_request(REQ_PUT, 31'd51, 32'sd44);
    send_request(REQ_PUT, 31'd67, 32'sd55);
    send_request(REQ_GET, 31'd99, 32'sd0);
    send_request(REQ_REMOVE, 31'd99, 32'sd0);
    send_request(REQ_REMOVE, 31'd19, 32'sd0);
    send_request(REQ_GET, 31'd19, 32'sd0);
    send_request(REQ_PUT, 31'd67, 32'sd55);
    send_request(REQ_GET, 31'd67, 32'sd0);
    send_request(REQ_GET, 31'd51, 32'sd0);
    send_request(REQ_UNUSED, 31'd3, 32'sd7);
    send_request(REQ_GET, 31'd3, 32'sd0);
    send_request(REQ_REMOVE, 31'h7fffffff, 32'sd0);
    send_request(REQ_GET, 31'h7fffffff, 32'sd0);

    refill_key_pool();
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      repeat (burst) begin
        send_request(pick_req(), pick_key(), pick_value());
        sent++;
        if (sent % 300 == 0) refill_key_pool();
        if (sent == RANDOM_ITEMS / 2) wait_all_results();
      end
      idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
    end

    wait_all_results();
    repeat (40) @(posedge clk_i);
    if (pred.pending.size() != 0) begin
      $error("%0d results never arrived", pred.pending.size());
      pred.errors++;
    end
    $display("Ran %0d requests: %0d new entries, %0d updates, %0d bucket-full refusals,",
             pred.n_req, pred.n_store, pred.n_update, pred.n_full);
    $display("%0d lookup hits, %0d removals and %0d absent-key outcomes.",
             pred.n_hit, pred.n_freed, pred.n_absent);
    if (pred.errors == 0) begin
      $display("hash_table_put_get_remove_unit test passed");
    end else begin
      $display("hash_table_put_get_remove_unit test failed");
    end
    $finish;
  end

endmodule
